// ----- rtl/uct_pkg.sv -----
// uct_pkg: shared types and constants for the url component tagger
// holds segment, verdict and phase codes plus the per-character result struct
// no dependencies
`default_nettype none

package uct_pkg;

  localparam int unsigned MaxSegmentLenDefault = 4096;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned ChW = 8;
  localparam int unsigned LimitW = 8;
  localparam logic [LimitW-1:0] PortHostLimitReset = 8'd15;

  // characters with a meaning to the parser
  localparam logic [ChW-1:0] ChColon = 8'h3A;
  localparam logic [ChW-1:0] ChSlash = 8'h2F;
  localparam logic [ChW-1:0] ChQuest = 8'h3F;
  localparam logic [ChW-1:0] ChHash = 8'h23;

  // segment tags
  localparam logic [2:0] SEG_SCHEME = 3'd0;
  localparam logic [2:0] SEG_SEP = 3'd1;
  localparam logic [2:0] SEG_HOST = 3'd2;
  localparam logic [2:0] SEG_PORT = 3'd3;
  localparam logic [2:0] SEG_PATH = 3'd4;
  localparam logic [2:0] SEG_QUERY = 3'd5;
  localparam logic [2:0] SEG_FRAG = 3'd6;
  localparam logic [2:0] SEG_DISCARD = 3'd7;

  // verdict codes, given on the last character
  localparam logic [2:0] VERD_OK = 3'd0;
  localparam logic [2:0] VERD_NO_COLON = 3'd1;
  localparam logic [2:0] VERD_BAD_SCHEME = 3'd2;
  localparam logic [2:0] VERD_NO_SLASH = 3'd3;
  localparam logic [2:0] VERD_HOST_OPEN = 3'd4;
  localparam logic [2:0] VERD_PORT_OPEN = 3'd5;

  typedef enum logic [8:0] {
    PH_SCHEME = 9'b0_0000_0001,
    PH_SLASH1 = 9'b0_0000_0010,
    PH_SLASH2 = 9'b0_0000_0100,
    PH_HOST   = 9'b0_0000_1000,
    PH_PORT   = 9'b0_0001_0000,
    PH_PATH   = 9'b0_0010_0000,
    PH_QUERY  = 9'b0_0100_0000,
    PH_FRAG   = 9'b0_1000_0000,
    PH_ERR    = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0]         segment;
    logic [OffsetW-1:0] offset;
    logic               url_done;
    logic [2:0]         verdict;
  } uct_result_t;

endpackage

`default_nettype wire

// ----- rtl/uct_parse.sv -----
// uct_parse: parse state machine and per-character tagging logic
// state updates on each advance; result is combinational from state and char
// depends on uct_pkg
`default_nettype none

module uct_parse #(
  parameter int unsigned MAX_SEGMENT_LEN = uct_pkg::MaxSegmentLenDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [uct_pkg::ChW-1:0]    ch,
  input  wire logic                       last,
  input  wire logic [uct_pkg::LimitW-1:0] port_host_limit,
  output uct_pkg::uct_result_t            result
);
  import uct_pkg::*;

  localparam int unsigned CapInt = ((MAX_SEGMENT_LEN - 1) < 4095) ? (MAX_SEGMENT_LEN - 1) : 4095;
  localparam logic [OffsetW-1:0] OffsetCap = OffsetW'(CapInt);

  phase_t             phase, phase_next;
  logic [OffsetW-1:0] seg_off, seg_off_next, seg_off_inc;
  logic               scheme_bad, scheme_bad_next;
  logic [2:0]         error_kind, error_kind_next;
  logic               is_letter;

  assign seg_off_inc = (seg_off < OffsetCap) ? seg_off + 1'b1 : seg_off;
  assign is_letter = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));

  always_comb begin
    phase_next = phase;
    seg_off_next = seg_off;
    scheme_bad_next = scheme_bad;
    error_kind_next = error_kind;
    result.segment = SEG_DISCARD;
    result.offset = '0;
    result.url_done = last;
    result.verdict = VERD_OK;

    unique case (phase)
      PH_SCHEME: begin
        if (ch == ChColon) begin
          if (scheme_bad) begin
            error_kind_next = VERD_BAD_SCHEME;
            phase_next = PH_ERR;
          end else begin
            result.segment = SEG_SEP;
            phase_next = PH_SLASH1;
          end
        end else begin
          if (!is_letter) begin
            scheme_bad_next = 1'b1;
          end
          result.segment = SEG_SCHEME;
          result.offset = seg_off;
          seg_off_next = seg_off_inc;
        end
      end
      PH_SLASH1, PH_SLASH2: begin
        if (ch == ChSlash) begin
          result.segment = SEG_SEP;
          result.offset = (phase == PH_SLASH1) ? OffsetW'(1) : OffsetW'(2);
          phase_next = (phase == PH_SLASH1) ? PH_SLASH2 : PH_HOST;
          seg_off_next = '0;
        end else begin
          error_kind_next = VERD_NO_SLASH;
          phase_next = PH_ERR;
        end
      end
      PH_HOST: begin
        if (ch == ChSlash) begin
          result.segment = SEG_SEP;
          phase_next = PH_PATH;
          seg_off_next = '0;
        end else if ((ch == ChColon) && (seg_off <= OffsetW'(port_host_limit))) begin
          result.segment = SEG_SEP;
          phase_next = PH_PORT;
          seg_off_next = '0;
        end else begin
          result.segment = SEG_HOST;
          result.offset = seg_off;
          seg_off_next = seg_off_inc;
        end
      end
      PH_PORT: begin
        if (ch == ChSlash) begin
          result.segment = SEG_SEP;
          phase_next = PH_PATH;
          seg_off_next = '0;
        end else begin
          result.segment = SEG_PORT;
          result.offset = seg_off;
          seg_off_next = seg_off_inc;
        end
      end
      PH_PATH: begin
        if ((ch == ChQuest) || (ch == ChHash)) begin
          result.segment = SEG_SEP;
          phase_next = (ch == ChQuest) ? PH_QUERY : PH_FRAG;
          seg_off_next = '0;
        end else begin
          result.segment = SEG_PATH;
          result.offset = seg_off;
          seg_off_next = seg_off_inc;
        end
      end
      PH_QUERY: begin
        if (ch == ChHash) begin
          result.segment = SEG_SEP;
          phase_next = PH_FRAG;
          seg_off_next = '0;
        end else begin
          result.segment = SEG_QUERY;
          result.offset = seg_off;
          seg_off_next = seg_off_inc;
        end
      end
      PH_FRAG: begin
        result.segment = SEG_FRAG;
        result.offset = seg_off;
        seg_off_next = seg_off_inc;
      end
      default: begin
        // error phase: everything is discarded until the last character
      end
    endcase

    if (last) begin
      priority if (error_kind_next != VERD_OK) begin
        result.verdict = error_kind_next;
      end else if (phase_next == PH_SCHEME) begin
        result.verdict = VERD_NO_COLON;
      end else if ((phase_next == PH_SLASH1) || (phase_next == PH_SLASH2)) begin
        result.verdict = VERD_NO_SLASH;
      end else if (phase_next == PH_HOST) begin
        result.verdict = VERD_HOST_OPEN;
      end else if (phase_next == PH_PORT) begin
        result.verdict = VERD_PORT_OPEN;
      end else begin
        result.verdict = VERD_OK;
      end
      phase_next = PH_SCHEME;
      seg_off_next = '0;
      scheme_bad_next = 1'b0;
      error_kind_next = VERD_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SCHEME;
      seg_off <= '0;
      scheme_bad <= 1'b0;
      error_kind <= VERD_OK;
    end else if (advance) begin
      phase <= phase_next;
      seg_off <= seg_off_next;
      scheme_bad <= scheme_bad_next;
      error_kind <= error_kind_next;
    end
  end

  // a url end always returns the parser to its start state
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> (phase == PH_SCHEME) && (seg_off == '0) && !scheme_bad
      && (error_kind == VERD_OK))
    else $error("parser state not cleared after last character");

  // an error is only ever recorded together with the error phase
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    (error_kind != VERD_OK) |-> (phase == PH_ERR))
    else $error("error kind set outside error phase");

  // the offset counter never passes its cap
  a_off_cap: assert property (@(posedge clk) disable iff (rst)
    seg_off <= OffsetCap)
    else $error("segment offset beyond cap");

endmodule

`default_nettype wire

// ----- rtl/url_component_tagger_core.sv -----
// url_component_tagger_core: top level of the url component tagger
// input register, parse logic (uct_parse) and result register
// depends on uct_pkg and uct_parse
//
// usage
//   characters of a url enter on the s_axis channel, one per transaction;
//   s_axis_tdata holds the character, s_axis_tlast marks the final one
//   every character yields exactly one result transaction on m_axis:
//   m_axis_tuser is the segment tag, m_axis_tdata carries the offset within
//   the segment and, on the last character, the verdict; m_axis_tlast
//   repeats the url end
//   the port_host_limit register is written through cfg_wr_en/cfg_wr_data; the user
//   must write it only while the block is idle, the block does not enforce this; reset value is 15
// timing
//   each result passes through the input register, then the result register;
//   one character per cycle sustained while m_axis_tready stays high, set by
//   the state update in the parse logic
// reset and stalls
//   rst (synchronous) empties both registers, returns the parser to the
//   scheme phase and reloads port_host_limit
//   when the receiver holds m_axis_tready low the result register holds,
//   the input register still fills once, then s_axis_tready drops
`default_nettype none

module url_component_tagger_core #(
  parameter int unsigned MAX_SEGMENT_LEN = uct_pkg::MaxSegmentLenDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: port_host_limit
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // input characters
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic        s_axis_tlast,   // last
  // tagged results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [11:0] offset, [14:12] verdict, [15] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] segment
  output logic             m_axis_tlast    // url_done
);
  import uct_pkg::*;

  logic [LimitW-1:0] port_host_limit;

  // input register
  logic           in_valid;
  logic [ChW-1:0] in_ch;
  logic           in_last;

  // result register
  logic        out_valid;
  uct_result_t out_res;

  uct_result_t res_next;
  logic        out_free;
  logic        advance;

  // the result register frees up when empty or drained this cycle
  assign out_free = !out_valid || m_axis_tready;
  // the held character moves into the result register and updates the parser
  assign advance = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_host_limit <= PortHostLimitReset;
    end else if (cfg_wr_en) begin
      port_host_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  uct_parse #(
    .MAX_SEGMENT_LEN(MAX_SEGMENT_LEN)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .ch             (in_ch),
    .last           (in_last),
    .port_host_limit(port_host_limit),
    .result         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {1'b0, out_res.verdict, out_res.offset};
  assign m_axis_tuser = out_res.segment;
  assign m_axis_tlast = out_res.url_done;

  // a verdict is only given on the last character of a url
  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[14:12] == VERD_OK))
    else $error("verdict on a character that is not last");

  // discarded characters and separators carry small fixed offsets
  a_discard_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((m_axis_tuser == SEG_DISCARD) || (m_axis_tuser == SEG_SEP))
      |-> (m_axis_tdata[11:0] <= 12'd2))
    else $error("offset too large for separator or discarded character");

  // the input register never drops a held character while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_ch) && $stable(in_last))
    else $error("input register lost a character under stall");

endmodule

`default_nettype wire
